// ----- src/htr_pkg.sv -----
package htr_pkg;

  localparam int unsigned DegPerSector = 60;
  localparam logic [8:0] HueLimit = 9'd360;
  localparam logic [5:0] SectorDeg = 6'd60;
  localparam logic [13:0] SectorScale = 14'd15300;

  // floor(x / 15300) == (x * RecipSector) >> RecipSectorShift for x < 255 * 15300.
  localparam logic [22:0] RecipSector = 23'd4491470;
  localparam int unsigned RecipSectorShift = 36;
  // floor(x / 255) == (x * RecipFull) >> RecipFullShift for x < 255 * 255.
  localparam logic [16:0] RecipFull = 17'd65794;
  localparam int unsigned RecipFullShift = 24;

  typedef enum logic [2:0] {
    SectorRed     = 3'd0,
    SectorYellow  = 3'd1,
    SectorGreen   = 3'd2,
    SectorCyan    = 3'd3,
    SectorBlue    = 3'd4,
    SectorMagenta = 3'd5
  } htr_sector_e;

  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } htr_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } htr_out_t;

  // Load enables of the three arithmetic stages.
  typedef struct packed {
    logic numer;
    logic prod;
    logic quot;
  } htr_math_en_t;

endpackage

// ----- src/htr_hue_split.sv -----
module htr_hue_split (
  input  logic [8:0]          hue_i,
  output htr_pkg::htr_sector_e sector_o,
  output logic [5:0]          rem_o,
  output logic                black_o
);

  logic [8:0] base;
  logic [8:0] diff;

  always_comb begin
    if (hue_i < 9'(htr_pkg::DegPerSector)) begin
      sector_o = htr_pkg::SectorRed;
      base     = 9'd0;
    end else if (hue_i < 9'(2 * htr_pkg::DegPerSector)) begin
      sector_o = htr_pkg::SectorYellow;
      base     = 9'(htr_pkg::DegPerSector);
    end else if (hue_i < 9'(3 * htr_pkg::DegPerSector)) begin
      sector_o = htr_pkg::SectorGreen;
      base     = 9'(2 * htr_pkg::DegPerSector);
    end else if (hue_i < 9'(4 * htr_pkg::DegPerSector)) begin
      sector_o = htr_pkg::SectorCyan;
      base     = 9'(3 * htr_pkg::DegPerSector);
    end else if (hue_i < 9'(5 * htr_pkg::DegPerSector)) begin
      sector_o = htr_pkg::SectorBlue;
      base     = 9'(4 * htr_pkg::DegPerSector);
    end else begin
      sector_o = htr_pkg::SectorMagenta;
      base     = 9'(5 * htr_pkg::DegPerSector);
    end
  end

  assign diff    = hue_i - base;
  // Out-of-range hues land in the last sector with a meaningless remainder; the black flag
  // overrides them at the output.
  assign rem_o   = diff[5:0];
  assign black_o = (hue_i >= htr_pkg::HueLimit);

endmodule

// ----- src/htr_channel_math.sv -----
module htr_channel_math (
  input  logic                 clk_i,
  input  htr_pkg::htr_math_en_t en_i,
  input  htr_pkg::htr_sector_e  sector_i,
  input  logic [5:0]           rem_i,
  input  logic [7:0]           sat_i,
  input  logic [7:0]           val_i,
  input  logic                 black_i,
  output htr_pkg::htr_sector_e  sector_o,
  output logic                 black_o,
  output logic [7:0]           val_o,
  output logic [7:0]           p_o,
  output logic [7:0]           q_o,
  output logic [7:0]           t_o
);

  // Numerator stage.
  logic [5:0]  comp;
  logic [13:0] s_rem;
  logic [13:0] s_comp;
  logic [13:0] nq_d, nq_q;
  logic [13:0] nt_d, nt_q;
  logic [7:0]  np_d, np_q;
  logic [7:0]  val_n_q;
  logic        black_n_q;
  htr_pkg::htr_sector_e sector_n_q;

  assign comp   = htr_pkg::SectorDeg - rem_i;
  assign s_rem  = {6'd0, sat_i} * {8'd0, rem_i};
  assign s_comp = {6'd0, sat_i} * {8'd0, comp};
  assign nq_d   = htr_pkg::SectorScale - s_rem;
  assign nt_d   = htr_pkg::SectorScale - s_comp;
  assign np_d   = ~sat_i;

  always_ff @(posedge clk_i) begin
    if (en_i.numer) begin
      nq_q       <= nq_d;
      nt_q       <= nt_d;
      np_q       <= np_d;
      val_n_q    <= val_i;
      black_n_q  <= black_i;
      sector_n_q <= sector_i;
    end
  end

  // Product stage: brightness times each numerator.
  logic [21:0] pq_d, pq_q;
  logic [21:0] pt_d, pt_q;
  logic [15:0] pp_d, pp_q;
  logic [7:0]  val_p_q;
  logic        black_p_q;
  htr_pkg::htr_sector_e sector_p_q;

  assign pq_d = {14'd0, val_n_q} * {8'd0, nq_q};
  assign pt_d = {14'd0, val_n_q} * {8'd0, nt_q};
  assign pp_d = {8'd0, val_n_q} * {8'd0, np_q};

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      pq_q       <= pq_d;
      pt_q       <= pt_d;
      pp_q       <= pp_d;
      val_p_q    <= val_n_q;
      black_p_q  <= black_n_q;
      sector_p_q <= sector_n_q;
    end
  end

  // Quotient stage: constant division by reciprocal multiply; the quotient never exceeds 255.
  logic [44:0] rq;
  logic [44:0] rt;
  logic [32:0] rp;
  logic [7:0]  q_q;
  logic [7:0]  t_q;
  logic [7:0]  p_q;
  logic [7:0]  val_r_q;
  logic        black_r_q;
  htr_pkg::htr_sector_e sector_r_q;

  assign rq = {23'd0, pq_q} * {22'd0, htr_pkg::RecipSector};
  assign rt = {23'd0, pt_q} * {22'd0, htr_pkg::RecipSector};
  assign rp = {17'd0, pp_q} * {16'd0, htr_pkg::RecipFull};

  always_ff @(posedge clk_i) begin
    if (en_i.quot) begin
      q_q        <= rq[htr_pkg::RecipSectorShift +: 8];
      t_q        <= rt[htr_pkg::RecipSectorShift +: 8];
      p_q        <= rp[htr_pkg::RecipFullShift +: 8];
      val_r_q    <= val_p_q;
      black_r_q  <= black_p_q;
      sector_r_q <= sector_p_q;
    end
  end

  assign sector_o = sector_r_q;
  assign black_o  = black_r_q;
  assign val_o    = val_r_q;
  assign p_o      = p_q;
  assign q_o      = q_q;
  assign t_o      = t_q;

endmodule

// ----- src/hsv_to_rgb_converter.sv -----
// HSV to RGB conversion, five register stages: hue split, numerators, brightness products,
// reciprocal-multiply quotients, and the sector routing into the output register.
// Throughput is one beat per cycle while the output is ready; each stage holds its beat while
// the next one cannot take it, so a stall at the output backs up through the pipeline with no loss.
// Reset clears only the stage valid bits; the data registers are not reset.
module hsv_to_rgb_converter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  htr_pkg::htr_in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output htr_pkg::htr_out_t out_data_o
);

  localparam int unsigned NumStages = 5;

  logic [NumStages-1:0] vld_d, vld_q;
  logic [NumStages-1:0] rdy;
  logic [NumStages-1:0] load;

  always_comb begin
    rdy[NumStages-1] = out_ready_i || !vld_q[NumStages-1];
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = rdy[k+1] || !vld_q[k];
    end
    for (int k = 0; k < NumStages; k++) begin
      if (rdy[k]) begin
        vld_d[k] = (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
      end else begin
        vld_d[k] = vld_q[k];
      end
      load[k] = rdy[k] && ((k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NumStages-1];

  // Stage 1: hue split.
  htr_pkg::htr_sector_e sector_s;
  logic [5:0]          rem_s;
  logic                black_s;

  htr_hue_split u_split (
    .hue_i    (in_data_i.hue),
    .sector_o (sector_s),
    .rem_o    (rem_s),
    .black_o  (black_s)
  );

  htr_pkg::htr_sector_e sector_q;
  logic [5:0]          rem_q;
  logic                black_q;
  logic [7:0]          sat_q;
  logic [7:0]          val_q;

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      sector_q <= sector_s;
      rem_q    <= rem_s;
      black_q  <= black_s;
      sat_q    <= in_data_i.saturation;
      val_q    <= in_data_i.brightness;
    end
  end

  // Stages 2 to 4: channel terms.
  htr_pkg::htr_math_en_t math_en;
  htr_pkg::htr_sector_e  sector_m;
  logic                 black_m;
  logic [7:0]           val_m;
  logic [7:0]           p_m;
  logic [7:0]           q_m;
  logic [7:0]           t_m;

  assign math_en.numer = load[1];
  assign math_en.prod  = load[2];
  assign math_en.quot  = load[3];

  htr_channel_math u_math (
    .clk_i    (clk_i),
    .en_i     (math_en),
    .sector_i (sector_q),
    .rem_i    (rem_q),
    .sat_i    (sat_q),
    .val_i    (val_q),
    .black_i  (black_q),
    .sector_o (sector_m),
    .black_o  (black_m),
    .val_o    (val_m),
    .p_o      (p_m),
    .q_o      (q_m),
    .t_o      (t_m)
  );

  // Stage 5: route the terms by sector.
  htr_pkg::htr_out_t out_d, out_q;

  always_comb begin
    case (sector_m)
      htr_pkg::SectorRed: begin
        out_d = '{red: val_m, green: t_m, blue: p_m};
      end
      htr_pkg::SectorYellow: begin
        out_d = '{red: q_m, green: val_m, blue: p_m};
      end
      htr_pkg::SectorGreen: begin
        out_d = '{red: p_m, green: val_m, blue: t_m};
      end
      htr_pkg::SectorCyan: begin
        out_d = '{red: p_m, green: q_m, blue: val_m};
      end
      htr_pkg::SectorBlue: begin
        out_d = '{red: t_m, green: p_m, blue: val_m};
      end
      default: begin
        out_d = '{red: val_m, green: p_m, blue: q_m};
      end
    endcase
    if (black_m) begin
      out_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- test/tb_hsv_to_rgb_converter.sv -----
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter;

  localparam int unsigned FullScale = 255;
  localparam int unsigned NumRandom = 1130;
  localparam int unsigned HoldBeat = 400;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned PauseItem = 600;
  localparam int unsigned MaxGap = 16;
  localparam int unsigned DrainCycles = 12;

  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
    logic       known;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_row_t;

  // Rows marked known carry a result that follows directly from the conversion rules;
  // the rest are checked against the color predictor.
  localparam int unsigned NumDirected = 23;
  localparam pixel_row_t DirectedRows [NumDirected] = '{
    '{9'd0,   8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
    '{9'd60,  8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd0},
    '{9'd120, 8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd0},
    '{9'd180, 8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd255},
    '{9'd240, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd255},
    '{9'd300, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd255},
    '{9'd359, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd360, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd0},
    '{9'd511, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd0},
    '{9'd400, 8'd128, 8'd77,  1'b1, 8'd0,   8'd0,   8'd0},
    '{9'd45,  8'd0,   8'd200, 1'b1, 8'd200, 8'd200, 8'd200},
    '{9'd275, 8'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
    '{9'd200, 8'd255, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    '{9'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    '{9'd30,  8'd128, 8'd200, 1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd90,  8'd200, 8'd100, 1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd150, 8'd77,  8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd210, 8'd255, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd270, 8'd1,   8'd254, 1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd330, 8'd170, 8'd85,  1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd59,  8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd1,   8'd1,   8'd1,   1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd256, 8'd85,  8'd170, 1'b0, 8'd0,   8'd0,   8'd0}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  htr_pkg::htr_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  htr_pkg::htr_out_t out_data_o;

  htr_pkg::htr_out_t offered_rgb;
  htr_pkg::htr_out_t rgb_expected_q [$];
  int unsigned       pixels_accepted;
  int unsigned       colors_checked;
  int unsigned       mismatch_count;
  int unsigned       sector_hits [6];
  int unsigned       black_hues;

  hsv_to_rgb_converter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic htr_pkg::htr_out_t hsv_pixel_to_rgb(htr_pkg::htr_in_t px);
    int unsigned          s;
    int unsigned          v;
    int unsigned          rem;
    int unsigned          p;
    int unsigned          q;
    int unsigned          t;
    htr_pkg::htr_sector_e sector;
    htr_pkg::htr_out_t    rgb;
    rgb = '0;
    if (px.hue < htr_pkg::HueLimit) begin
      sector = htr_pkg::htr_sector_e'(3'(px.hue / htr_pkg::DegPerSector));
      rem = px.hue % htr_pkg::DegPerSector;
      s = px.saturation;
      v = px.brightness;
      p = (v * (FullScale - s)) / FullScale;
      q = (v * (htr_pkg::SectorScale - s * rem)) / htr_pkg::SectorScale;
      t = (v * (htr_pkg::SectorScale - s * (htr_pkg::DegPerSector - rem))) /
          htr_pkg::SectorScale;
      case (sector)
        htr_pkg::SectorRed: begin
          rgb = '{8'(v), 8'(t), 8'(p)};
        end
        htr_pkg::SectorYellow: begin
          rgb = '{8'(q), 8'(v), 8'(p)};
        end
        htr_pkg::SectorGreen: begin
          rgb = '{8'(p), 8'(v), 8'(t)};
        end
        htr_pkg::SectorCyan: begin
          rgb = '{8'(p), 8'(q), 8'(v)};
        end
        htr_pkg::SectorBlue: begin
          rgb = '{8'(t), 8'(p), 8'(v)};
        end
        default: begin
          rgb = '{8'(v), 8'(p), 8'(q)};
        end
      endcase
    end
    return rgb;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic offer_pixel(input htr_pkg::htr_in_t px, input htr_pkg::htr_out_t rgb,
                             input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_data_i   <= px;
    offered_rgb <= rgb;
    if (px.hue < htr_pkg::HueLimit) begin
      sector_hits[px.hue / htr_pkg::DegPerSector]++;
    end else begin
      black_hues++;
    end
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_for_drain();
    while (rgb_expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : color_scoreboard
    htr_pkg::htr_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        colors_checked++;
        if (rgb_expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: output beat with nothing pending: r=%0d g=%0d b=%0d", $realtime,
                     out_data_o.red, out_data_o.green, out_data_o.blue);
          end
        end else begin
          want = rgb_expected_q.pop_front();
          if (out_data_o.red !== want.red || out_data_o.green !== want.green ||
              out_data_o.blue !== want.blue) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       $realtime, want.red, want.green, want.blue,
                       out_data_o.red, out_data_o.green, out_data_o.blue);
            end
          end
        end
      end
      // The input is registered before it can reach the output, so the beat taken here cannot leave at this edge.
      if (in_valid_i && in_ready_o) begin
        rgb_expected_q.insert(rgb_expected_q.size(), offered_rgb);
        pixels_accepted++;
      end
    end
  end

  // Output side: random stalls, quiet stretches, and one long hold-off that backs up the pipe.
  initial begin : color_sink
    int unsigned beats;
    int unsigned stall;
    beats = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (beats == HoldBeat) begin
        stall = HoldCycles;
      end else if (beats % 100 < 30) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, MaxGap);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      beats++;
      @(negedge clk_i);
    end
  end

  initial begin : pixel_source
    htr_pkg::htr_in_t  px;
    htr_pkg::htr_out_t rgb;
    int unsigned       gap;
    int unsigned       pick;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    offered_rgb     = '0;
    pixels_accepted = 0;
    colors_checked  = 0;
    mismatch_count  = 0;
    black_hues      = 0;
    foreach (sector_hits[i]) sector_hits[i] = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      px = '{DirectedRows[i].hue, DirectedRows[i].saturation, DirectedRows[i].brightness};
      if (DirectedRows[i].known) begin
        rgb = '{DirectedRows[i].red, DirectedRows[i].green, DirectedRows[i].blue};
      end else begin
        rgb = hsv_pixel_to_rgb(px);
      end
      gap = (i % 2 == 0) ? 0 : $urandom_range(0, MaxGap);
      offer_pixel(px, rgb, gap);
    end
    in_valid_i <= 1'b0;
    wait_for_drain();

    for (int unsigned n = 0; n < NumRandom; n++) begin
      if (n == PauseItem) begin
        in_valid_i <= 1'b0;
        wait_for_drain();
      end
      // Mostly in-range hues; saturation and brightness lean on their end points now and then.
      px.hue = ($urandom_range(0, 99) < 85) ? 9'($urandom_range(0, 359))
                                              : 9'($urandom_range(360, 511));
      pick = $urandom_range(0, 9);
      px.saturation = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 9);
      px.brightness = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255));
      gap = (n % 100 < 25) ? 0 : $urandom_range(0, MaxGap);
      offer_pixel(px, hsv_pixel_to_rgb(px), gap);
    end
    in_valid_i <= 1'b0;
    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);

    mismatch_count += rgb_expected_q.size();
    $display("Converted %0d pixels, %0d colors checked; sector hits %0d/%0d/%0d/%0d/%0d/%0d,",
             pixels_accepted, colors_checked, sector_hits[0], sector_hits[1], sector_hits[2],
             sector_hits[3], sector_hits[4], sector_hits[5]);
    $display("%0d out-of-range hues, %0d mismatches.", black_hues, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Timed out with %0d colors still pending.", rgb_expected_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
src/htr_pkg.sv
src/htr_hue_split.sv
src/htr_channel_math.sv
src/hsv_to_rgb_converter.sv
test/tb_hsv_to_rgb_converter.sv
